// File: hw/rtl/lpzmt_pkg.sv
// lpzmt_pkg: shared types and constants for the scan packet zone-minimum tracker.
// No dependencies; used by the channel interfaces, the top level and its checker.

package lpzmt_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIST_W  = 16;
    localparam int ANGLE_W = 15;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // 360 degrees in q6 degrees; empty-zone mark for the running minima
    localparam logic [ANGLE_W-1:0] ANGLE_FULL_TURN = 15'd23040;
    localparam logic [DIST_W-1:0]  NONE_MARK       = 16'hFFFF;

    // register reset values
    localparam logic [DIST_W-1:0]  MIN_DIST_RST     = 16'd400;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST     = 16'd48000;
    localparam logic [ANGLE_W-1:0] LEFT_START_RST   = 15'd20160;
    localparam logic [ANGLE_W-1:0] CENTER_START_RST = 15'd22080;
    localparam logic [ANGLE_W-1:0] RIGHT_START_RST  = 15'd960;
    localparam logic [ANGLE_W-1:0] RIGHT_END_RST    = 15'd2880;

    // register indexes (word address = paddr[4:2])
    localparam logic [2:0] REG_MIN_DIST     = 3'd0;
    localparam logic [2:0] REG_MAX_DIST     = 3'd1;
    localparam logic [2:0] REG_LEFT_START   = 3'd2;
    localparam logic [2:0] REG_CENTER_START = 3'd3;
    localparam logic [2:0] REG_RIGHT_START  = 3'd4;
    localparam logic [2:0] REG_RIGHT_END    = 3'd5;

    typedef struct packed {
        logic [DIST_W-1:0] left_min;
        logic [DIST_W-1:0] center_min;
        logic [DIST_W-1:0] right_min;
    } zone_report_t;

endpackage

// File: hw/rtl/lpzmt_ifs.sv
// lpzmt_ifs: valid/ready channel interfaces for received bytes and zone reports.
// Depends on lpzmt_pkg for field widths.

interface lpzmt_rx_if;
    logic                        valid;
    logic                        ready;
    logic [lpzmt_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpzmt_zone_if;
    logic                        valid;
    logic                        ready;
    logic [lpzmt_pkg::DIST_W-1:0] left_min;
    logic [lpzmt_pkg::DIST_W-1:0] center_min;
    logic [lpzmt_pkg::DIST_W-1:0] right_min;

    modport source (output valid, output left_min, output center_min, output right_min,
                    input ready);
    modport sink   (input valid, input left_min, input center_min, input right_min,
                    output ready);
endinterface

// File: hw/rtl/lidar_packet_zone_min_tracker.sv
// lidar_packet_zone_min_tracker: frames 5-byte scan packets and tracks per-zone minima.
// Depends on lpzmt_pkg and the channel interfaces in lpzmt_ifs.

// Bytes from the range sensor's serial link enter on rx, one beat per byte. The block
// holds up to four bytes and, on the fifth, checks the packet (byte0 bit0 != byte0 bit1,
// byte1 bit0 set). A bad packet drops its oldest byte and framing slides on by one. A good
// packet yields one point: angle (b1>>1)|(b2<<7) in q6 degrees, one full turn taken off
// if it reaches 360, and distance b3|b4<<8 in q2 mm. A packet with the start flag
// (byte0 bit0) first emits one beat on zone with the previous scan's left, center and
// right minima (0 for a zone that saw nothing) and clears them; its own point then counts
// for the new scan. Points below the low distance limit or above the high distance limit
// are dropped. Bytes pass an input register and the packet logic behind it is
// combinational; a report is held in an output register that drives zone. A byte is
// accepted every cycle unless rx stalls, which happens only when a start packet sits in
// the input register while the previous report is still waiting on zone.
// Registers sit on an APB port at 4*index and should be written only while the block is
// idle; pready is always high.

module lidar_packet_zone_min_tracker (
    input  logic                               clk,
    input  logic                               rst_n,
    lpzmt_rx_if.sink                           rx,
    lpzmt_zone_if.source                       zone,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpzmt_pkg::ADDR_W-1:0]       paddr,
    input  logic [lpzmt_pkg::DATA_W-1:0]       pwdata,
    output logic [lpzmt_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);

    // ---------------- configuration registers ----------------
    logic [lpzmt_pkg::DIST_W-1:0]  min_dist_reg;
    logic [lpzmt_pkg::DIST_W-1:0]  max_dist_reg;
    logic [lpzmt_pkg::ANGLE_W-1:0] left_start_reg;
    logic [lpzmt_pkg::ANGLE_W-1:0] center_start_reg;
    logic [lpzmt_pkg::ANGLE_W-1:0] right_start_reg;
    logic [lpzmt_pkg::ANGLE_W-1:0] right_end_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg     <= lpzmt_pkg::MIN_DIST_RST;
            max_dist_reg     <= lpzmt_pkg::MAX_DIST_RST;
            left_start_reg   <= lpzmt_pkg::LEFT_START_RST;
            center_start_reg <= lpzmt_pkg::CENTER_START_RST;
            right_start_reg  <= lpzmt_pkg::RIGHT_START_RST;
            right_end_reg    <= lpzmt_pkg::RIGHT_END_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lpzmt_pkg::REG_MIN_DIST:     min_dist_reg     <= pwdata[15:0];
                lpzmt_pkg::REG_MAX_DIST:     max_dist_reg     <= pwdata[15:0];
                lpzmt_pkg::REG_LEFT_START:   left_start_reg   <= pwdata[14:0];
                lpzmt_pkg::REG_CENTER_START: center_start_reg <= pwdata[14:0];
                lpzmt_pkg::REG_RIGHT_START:  right_start_reg  <= pwdata[14:0];
                lpzmt_pkg::REG_RIGHT_END:    right_end_reg    <= pwdata[14:0];
                default:                     ;  // unmapped words ignore writes
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lpzmt_pkg::REG_MIN_DIST:     prdata = {16'd0, min_dist_reg};
            lpzmt_pkg::REG_MAX_DIST:     prdata = {16'd0, max_dist_reg};
            lpzmt_pkg::REG_LEFT_START:   prdata = {17'd0, left_start_reg};
            lpzmt_pkg::REG_CENTER_START: prdata = {17'd0, center_start_reg};
            lpzmt_pkg::REG_RIGHT_START:  prdata = {17'd0, right_start_reg};
            lpzmt_pkg::REG_RIGHT_END:    prdata = {17'd0, right_end_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [lpzmt_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                          s1_advance;
    logic                          rx_take;

    // ---------------- framing and scan state ----------------
    logic [lpzmt_pkg::BYTE_W-1:0]  held_reg [4];
    logic [2:0]                    held_count_reg;
    logic [2:0]                    held_count_next;
    logic [lpzmt_pkg::DIST_W-1:0]  left_best_reg;
    logic [lpzmt_pkg::DIST_W-1:0]  center_best_reg;
    logic [lpzmt_pkg::DIST_W-1:0]  right_best_reg;
    logic [lpzmt_pkg::DIST_W-1:0]  left_best_next;
    logic [lpzmt_pkg::DIST_W-1:0]  center_best_next;
    logic [lpzmt_pkg::DIST_W-1:0]  right_best_next;

    // ---------------- output register ----------------
    logic                          out_valid_reg;
    logic                          out_valid_next;
    lpzmt_pkg::zone_report_t       out_report_reg;
    lpzmt_pkg::zone_report_t       out_report_next;

    // packet decode
    logic                          pkt_full;
    logic                          start_flag;
    logic                          pkt_ok;
    logic                          is_start;
    logic [lpzmt_pkg::ANGLE_W-1:0] raw_angle;
    logic [lpzmt_pkg::ANGLE_W-1:0] angle;
    logic [lpzmt_pkg::DIST_W-1:0]  point_dist;
    logic                          dist_ok;
    logic                          in_left;
    logic                          in_center;
    logic                          in_right;
    logic [lpzmt_pkg::DIST_W-1:0]  left_base;
    logic [lpzmt_pkg::DIST_W-1:0]  center_base;
    logic [lpzmt_pkg::DIST_W-1:0]  right_base;

    function automatic logic [lpzmt_pkg::DIST_W-1:0] report_of(
        input logic [lpzmt_pkg::DIST_W-1:0] best
    );
        return (best == lpzmt_pkg::NONE_MARK) ? '0 : best;
    endfunction

    assign pkt_full   = (held_count_reg >= 3'd4);
    assign start_flag = held_reg[0][0];
    // good packet: start and inverted-start bits differ, check bit set
    assign pkt_ok     = pkt_full && (held_reg[0][0] != held_reg[0][1]) && held_reg[1][0];
    assign is_start   = pkt_ok && start_flag;

    // a start packet needs the output register free (or being drained)
    assign s1_advance = s1_valid_reg && (!out_valid_reg || zone.ready || !is_start);
    assign rx.ready   = !s1_valid_reg || s1_advance;
    assign rx_take    = rx.valid && rx.ready;

    assign raw_angle  = {held_reg[2], held_reg[1][7:1]};
    assign angle      = (raw_angle >= lpzmt_pkg::ANGLE_FULL_TURN)
                        ? raw_angle - lpzmt_pkg::ANGLE_FULL_TURN : raw_angle;
    assign point_dist = {s1_byte_reg, held_reg[3]};
    assign dist_ok    = (point_dist >= min_dist_reg) && (point_dist <= max_dist_reg);

    // zone priority: left, then center (wraps through 0), then right
    assign in_left   = (angle >= left_start_reg) && (angle < center_start_reg);
    assign in_center = !in_left && ((angle >= center_start_reg) || (angle < right_start_reg));
    assign in_right  = !in_left && !in_center
                       && (angle >= right_start_reg) && (angle < right_end_reg);

    // a start packet clears the minima before its own point is taken
    assign left_base   = is_start ? lpzmt_pkg::NONE_MARK : left_best_reg;
    assign center_base = is_start ? lpzmt_pkg::NONE_MARK : center_best_reg;
    assign right_base  = is_start ? lpzmt_pkg::NONE_MARK : right_best_reg;

    always_comb
    begin
        s1_valid_next    = s1_advance ? 1'b0 : s1_valid_reg;
        if (rx_take)
            s1_valid_next = 1'b1;

        held_count_next  = held_count_reg;
        left_best_next   = left_best_reg;
        center_best_next = center_best_reg;
        right_best_next  = right_best_reg;
        out_valid_next   = zone.ready ? 1'b0 : out_valid_reg;
        out_report_next  = out_report_reg;

        if (s1_advance)
        begin
            if (!pkt_full)
                held_count_next = held_count_reg + 3'd1;
            else if (!pkt_ok)
                held_count_next = 3'd4;
            else
            begin
                held_count_next = 3'd0;
                left_best_next  = (dist_ok && in_left && point_dist < left_base)
                                  ? point_dist : left_base;
                center_best_next = (dist_ok && in_center && point_dist < center_base)
                                   ? point_dist : center_base;
                right_best_next = (dist_ok && in_right && point_dist < right_base)
                                  ? point_dist : right_base;
                if (start_flag)
                begin
                    out_valid_next             = 1'b1;
                    out_report_next.left_min   = report_of(left_best_reg);
                    out_report_next.center_min = report_of(center_best_reg);
                    out_report_next.right_min  = report_of(right_best_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            held_count_reg  <= 3'd0;
            left_best_reg   <= lpzmt_pkg::NONE_MARK;
            center_best_reg <= lpzmt_pkg::NONE_MARK;
            right_best_reg  <= lpzmt_pkg::NONE_MARK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            held_count_reg  <= held_count_next;
            left_best_reg   <= left_best_next;
            center_best_reg <= center_best_next;
            right_best_reg  <= right_best_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rx_take)
            s1_byte_reg <= rx.rx_byte;
        out_report_reg <= out_report_next;
        if (s1_advance)
        begin
            if (!pkt_full)
                held_reg[held_count_reg[1:0]] <= s1_byte_reg;
            else if (!pkt_ok)
            begin
                // slide window: drop oldest byte
                held_reg[0] <= held_reg[1];
                held_reg[1] <= held_reg[2];
                held_reg[2] <= held_reg[3];
                held_reg[3] <= s1_byte_reg;
            end
        end
    end

    assign zone.valid      = out_valid_reg;
    assign zone.left_min   = out_report_reg.left_min;
    assign zone.center_min = out_report_reg.center_min;
    assign zone.right_min  = out_report_reg.right_min;

endmodule

// File: hw/rtl/lpzmt_checker.sv
// lpzmt_checker: port-level assertions for lidar_packet_zone_min_tracker, bound to it.
// Depends on lpzmt_pkg for widths and on the top level for the bind.

module lpzmt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rx_valid,
    input logic                         rx_ready,
    input logic                         zone_valid,
    input logic                         zone_ready,
    input logic [lpzmt_pkg::DIST_W-1:0] left_min,
    input logic [lpzmt_pkg::DIST_W-1:0] center_min,
    input logic [lpzmt_pkg::DIST_W-1:0] right_min
);

    // no report beat while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !zone_valid)
        else $error("report valid during reset");

    // a stalled report stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        zone_valid && !zone_ready |=> zone_valid)
        else $error("report dropped while stalled");

    // a stalled report keeps its fields
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        zone_valid && !zone_ready |=> $stable(left_min) && $stable(center_min)
                                      && $stable(right_min))
        else $error("report changed while stalled");

    // a draining output never blocks incoming bytes
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        zone_ready |-> rx_ready)
        else $error("byte stalled while output drains");

    // a fresh report goes valid only after an accepted byte beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(zone_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("report without matching byte beat");

endmodule

bind lidar_packet_zone_min_tracker lpzmt_checker u_lpzmt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .zone_valid (zone.valid),
    .zone_ready (zone.ready),
    .left_min   (zone.left_min),
    .center_min (zone.center_min),
    .right_min  (zone.right_min)
);
